@@ hw/rtl/grm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package grm_pkg;

  // Fixed field widths
  localparam int unsigned CONTENT_W   = 32;
  localparam int unsigned ERR_W       = 24;
  localparam int unsigned CFG_W       = 7;
  localparam int unsigned BINS_USED_W = 7;

  // Group size after reset
  localparam logic [CFG_W-1:0] GROUP_SIZE_RST = 7'd20;

  typedef logic [CFG_W-1:0] cfg_t;

  typedef struct packed {
    logic signed [CONTENT_W-1:0] bin_content;
    logic        [ERR_W-1:0]     bin_error;
  } bin_t;

  typedef struct packed {
    logic signed [CONTENT_W-1:0]   group_mean;
    logic        [ERR_W-1:0]       group_error;
    logic        [BINS_USED_W-1:0] bins_used;
  } result_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_DIV_MEAN,
    ST_DIV_ERR,
    ST_RESULT
  } grm_state_e;

endpackage

`default_nettype wire

@@ hw/rtl/grm_stream_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface grm_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/grm_accum.sv @@
`timescale 1ns / 1ps
`default_nettype none

module grm_accum #(
  parameter int unsigned SUM_W = 38,
  parameter int unsigned SQS_W = 54,
  parameter int unsigned CNT_W = 7
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                take_i,
  input  wire logic                                clear_i,
  input  wire logic signed [grm_pkg::CONTENT_W-1:0] content_i,
  input  wire logic        [grm_pkg::ERR_W-1:0]     error_i,
  output logic signed      [SUM_W-1:0]             content_sum_o,
  output logic             [SQS_W-1:0]             square_sum_o,
  output logic             [CNT_W-1:0]             count_o,
  output logic                                     busy_o
);
  import grm_pkg::*;

  localparam int unsigned PROD_W = 2 * ERR_W;

  logic signed [SUM_W-1:0]  sum_q;
  logic        [SQS_W-1:0]  sqs_q;
  logic        [CNT_W-1:0]  cnt_q;
  logic        [PROD_W-1:0] mcand_q;
  logic        [ERR_W-1:0]  mplier_q;
  logic                     nonzero;

  assign nonzero = (content_i != '0);

  // Sums, count and a shift-add squarer, one multiplier bit a cycle while no clear or take comes in
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      sqs_q    <= '0;
      cnt_q    <= '0;
      mcand_q  <= '0;
      mplier_q <= '0;
    end else if (clear_i) begin
      sum_q <= '0;
      sqs_q <= '0;
      cnt_q <= '0;
    end else if (take_i && nonzero) begin
      sum_q    <= sum_q + SUM_W'(content_i);
      cnt_q    <= cnt_q + CNT_W'(1);
      mcand_q  <= PROD_W'(error_i);
      mplier_q <= error_i;
    end else if (mplier_q != '0) begin
      if (mplier_q[0]) begin
        sqs_q <= sqs_q + SQS_W'(mcand_q);
      end
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
    end
  end

  assign content_sum_o = sum_q;
  assign square_sum_o  = sqs_q;
  assign count_o       = cnt_q;
  assign busy_o        = (mplier_q != '0);

endmodule

`default_nettype wire

@@ hw/rtl/grm_sqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none

module grm_sqrt #(
  parameter int unsigned IN_W = 54
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [IN_W-1:0]           radicand_i,
  output logic                           busy_o,
  output logic      [(IN_W+1)/2-1:0]     root_o
);

  localparam int unsigned RT_W   = (IN_W + 1) / 2;
  localparam int unsigned PAD_W  = 2 * RT_W;
  localparam int unsigned ITER_W = $clog2(RT_W + 1);

  logic [PAD_W-1:0]  rad_q;
  logic [RT_W-1:0]   root_q;
  logic [RT_W:0]     rem_q;
  logic [ITER_W-1:0] iter_q;
  logic [RT_W+2:0]   rem_t;
  logic [RT_W+2:0]   trial;
  logic [RT_W+2:0]   diff;
  logic              fits;

  // One root bit a cycle: bring down two radicand bits, try 4r+1
  always_comb begin
    rem_t = {rem_q, rad_q[PAD_W-1 -: 2]};
    trial = {1'b0, root_q, 2'b01};
    fits  = (rem_t >= trial);
    diff  = rem_t - trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q  <= '0;
      root_q <= '0;
      rem_q  <= '0;
      iter_q <= '0;
    end else if (start_i) begin
      rad_q  <= PAD_W'(radicand_i);
      root_q <= '0;
      rem_q  <= '0;
      iter_q <= ITER_W'(RT_W);
    end else if (iter_q != '0) begin
      rad_q  <= rad_q << 2;
      root_q <= {root_q[RT_W-2:0], fits};
      rem_q  <= fits ? diff[RT_W:0] : rem_t[RT_W:0];
      iter_q <= iter_q - ITER_W'(1);
    end
  end

  assign busy_o = (iter_q != '0);
  assign root_o = root_q;

endmodule

`default_nettype wire

@@ hw/rtl/grm_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module grm_div #(
  parameter int unsigned N_W = 38,
  parameter int unsigned D_W = 7
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [N_W-1:0] dividend_i,
  input  wire logic [D_W-1:0] divisor_i,
  output logic                busy_o,
  output logic      [N_W-1:0] quotient_o
);

  localparam int unsigned ITER_W = $clog2(N_W + 1);

  logic [N_W-1:0]    quo_q;
  logic [D_W-1:0]    rem_q;
  logic [D_W-1:0]    dvs_q;
  logic [ITER_W-1:0] iter_q;
  logic [D_W:0]      rem_t;
  logic [D_W:0]      diff;
  logic              fits;

  // Restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_t = {rem_q, quo_q[N_W-1]};
    fits  = (rem_t >= {1'b0, dvs_q});
    diff  = rem_t - {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      iter_q <= '0;
    end else if (start_i) begin
      quo_q  <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
      iter_q <= ITER_W'(N_W);
    end else if (iter_q != '0) begin
      quo_q  <= {quo_q[N_W-2:0], fits};
      rem_q  <= fits ? diff[D_W-1:0] : rem_t[D_W-1:0];
      iter_q <= iter_q - ITER_W'(1);
    end
  end

  assign busy_o     = (iter_q != '0);
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

@@ hw/rtl/group_mean_rebinner_core.sv @@
// Channel   Dir  Payload                                  Request taken when
// bin_i     in   bin_content, bin_error                   valid & ready
// cfg_i     in   group_size                               valid & ready (ready always high)
// result_o  out  group_mean, group_error, bins_used       valid & ready
//
// A bin passes through ST_IDLE and ST_SQUARE. For a nonzero bin, ST_SQUARE waits while
// the shift-add squarer works through its error up to the top set bit (at most ERR_W
// bits). A group end with nonzero bins then runs the root (ST_ROOT) and the mean and
// error divides (ST_DIV_MEAN, ST_DIV_ERR) before ST_RESULT; an empty group skips them.
// Reset clears all sums and sets the group size to 20. A result waits in the
// output register; the next bin is taken meanwhile, only the next group end stalls.
`timescale 1ns / 1ps
`default_nettype none

module group_mean_rebinner_core #(
  parameter int unsigned MAX_GROUP = 64
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  grm_stream_if.sink   bin_i,
  grm_stream_if.sink   cfg_i,
  grm_stream_if.source result_o
);
  import grm_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_GROUP + 1);
  localparam int unsigned SUM_W  = CONTENT_W + $clog2(MAX_GROUP);
  localparam int unsigned SQS_W  = 2 * ERR_W + $clog2(MAX_GROUP);
  localparam int unsigned ROOT_W = (SQS_W + 1) / 2;

  grm_state_e state_q, state_d;

  cfg_t                    gs_q;
  logic [CNT_W-1:0]        pos_q;
  logic                    end_q;
  logic [SUM_W-1:0]        mean_q;
  logic [ERR_W-1:0]        err_q;
  logic                    out_valid_q;
  result_t                 out_q;

  logic [CNT_W-1:0]        eff_size;
  logic [CNT_W:0]          pos_inc;
  logic                    group_end;
  logic                    bin_take;
  logic                    result_load;
  logic                    sqrt_start;
  logic                    div_start;
  logic [SUM_W-1:0]        div_dividend;
  logic [SUM_W-1:0]        sum_mag;

  logic signed [SUM_W-1:0] content_sum;
  logic [SQS_W-1:0]        square_sum;
  logic [CNT_W-1:0]        count;
  logic                    acc_busy;
  logic                    sq_busy;
  logic [ROOT_W-1:0]       root;
  logic                    div_busy;
  logic [SUM_W-1:0]        quotient;

  // Config register, always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gs_q <= GROUP_SIZE_RST;
    end else if (cfg_i.valid) begin
      gs_q <= cfg_i.data;
    end
  end

  // Effective group size: zero acts as one, large values saturate
  always_comb begin
    priority if (gs_q == '0) begin
      eff_size = CNT_W'(1);
    end else if (int'(gs_q) > int'(MAX_GROUP)) begin
      eff_size = CNT_W'(MAX_GROUP);
    end else begin
      eff_size = CNT_W'(gs_q);
    end
  end

  assign bin_i.ready = (state_q == ST_IDLE);
  assign bin_take    = bin_i.valid && (state_q == ST_IDLE);
  assign pos_inc     = (CNT_W+1)'(pos_q) + (CNT_W+1)'(1);
  assign group_end   = (pos_inc >= {1'b0, eff_size});

  // Group position and end flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      end_q <= 1'b0;
    end else if (bin_take) begin
      end_q <= group_end;
      pos_q <= group_end ? '0 : pos_inc[CNT_W-1:0];
    end
  end

  grm_accum #(
    .SUM_W (SUM_W),
    .SQS_W (SQS_W),
    .CNT_W (CNT_W)
  ) u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (bin_take),
    .clear_i       (result_load),
    .content_i     (bin_i.data.bin_content),
    .error_i       (bin_i.data.bin_error),
    .content_sum_o (content_sum),
    .square_sum_o  (square_sum),
    .count_o       (count),
    .busy_o        (acc_busy)
  );

  grm_sqrt #(
    .IN_W (SQS_W)
  ) u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (square_sum),
    .busy_o     (sq_busy),
    .root_o     (root)
  );

  grm_div #(
    .N_W (SUM_W),
    .D_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (count),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  // Magnitude of the content sum for the unsigned divider
  assign sum_mag = content_sum[SUM_W-1] ? $unsigned(-content_sum) : $unsigned(content_sum);

  // Sequencer: state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequencer: next state and strobes
  always_comb begin
    state_d      = state_q;
    sqrt_start   = 1'b0;
    div_start    = 1'b0;
    div_dividend = sum_mag;
    result_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (bin_i.valid) begin
          state_d = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (!acc_busy) begin
          priority if (!end_q) begin
            state_d = ST_IDLE;
          end else if (count == '0) begin
            state_d = ST_RESULT;
          end else begin
            sqrt_start = 1'b1;
            state_d    = ST_ROOT;
          end
        end
      end
      ST_ROOT: begin
        if (!sq_busy) begin
          div_start = 1'b1;
          state_d   = ST_DIV_MEAN;
        end
      end
      ST_DIV_MEAN: begin
        div_dividend = SUM_W'(root);
        if (!div_busy) begin
          div_start = 1'b1;
          state_d   = ST_DIV_ERR;
        end
      end
      ST_DIV_ERR: begin
        if (!div_busy) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_q || result_o.ready) begin
          result_load = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Quotient capture; mean truncates toward zero
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIV_MEAN && !div_busy) begin
      mean_q <= content_sum[SUM_W-1] ? (-quotient) : quotient;
    end
    if (state_q == ST_DIV_ERR && !div_busy) begin
      err_q <= ERR_W'(quotient);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (result_load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result_load) begin
      if (count == '0) begin
        out_q <= '0;
      end else begin
        out_q.group_mean  <= CONTENT_W'(mean_q);
        out_q.group_error <= err_q;
        out_q.bins_used   <= BINS_USED_W'(count);
      end
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

endmodule

`default_nettype wire

@@ tb/sv/tb_group_mean_rebinner_core.sv @@
`timescale 1ns / 1ps

module tb_group_mean_rebinner_core;
  import grm_pkg::*;

  localparam int unsigned MAX_GROUP     = 64;
  localparam int unsigned STALL_LIMIT   = 3000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned TAIL_CYCLES   = 200;

  localparam logic signed [CONTENT_W-1:0] CONTENT_MIN = 32'sh8000_0000;
  localparam logic signed [CONTENT_W-1:0] CONTENT_MAX = 32'sh7FFF_FFFF;
  localparam logic [ERR_W-1:0]            ERR_MAX     = 24'hFF_FFFF;

  typedef enum int {
    IDLE_OFF,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  logic clk = 1'b0;
  logic rst_n;

  grm_stream_if #(.payload_t(bin_t))    bin_if ();
  grm_stream_if #(.payload_t(cfg_t))    cfg_if ();
  grm_stream_if #(.payload_t(result_t)) res_if ();

  group_mean_rebinner_core #(
    .MAX_GROUP(MAX_GROUP)
  ) u_top (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .bin_i   (bin_if),
    .cfg_i   (cfg_if),
    .result_o(res_if)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the rebinner state, advanced on every accepted bin
  cfg_t                 group_size_q;
  logic signed [37:0]   content_sum_q;
  logic        [53:0]   err_sq_sum_q;
  logic        [6:0]    nonzero_q;
  logic        [6:0]    position_q;
  result_t              expected_groups [$];

  int unsigned errors    = 0;
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_req  = 0;

  // Floor of the square root, one result bit per step from the top
  function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root[31:0];
  endfunction

  function automatic void accumulate_bin(input bin_t b);
    logic        [53:0] e;
    logic        [6:0]  span;
    logic signed [37:0] quotient;
    logic        [31:0] root;
    result_t            r;
    e = {30'd0, b.bin_error};
    if (b.bin_content != 0) begin
      content_sum_q = content_sum_q + $signed(b.bin_content);
      err_sq_sum_q  = err_sq_sum_q + e * e;
      nonzero_q     = nonzero_q + 7'd1;
    end
    position_q = position_q + 7'd1;

    // zero acts as one, oversize saturates
    if (group_size_q == 0) span = 7'd1;
    else if (group_size_q > MAX_GROUP) span = 7'(MAX_GROUP);
    else span = group_size_q;

    if (position_q >= span) begin
      r = '0;
      if (nonzero_q != 0) begin
        quotient      = content_sum_q / $signed({31'd0, nonzero_q});
        root          = floor_sqrt({10'd0, err_sq_sum_q});
        r.group_mean  = quotient[31:0];
        r.group_error = 24'(root / {25'd0, nonzero_q});
        r.bins_used   = nonzero_q;
      end
      expected_groups.push_back(r);
      content_sum_q = '0;
      err_sq_sum_q  = '0;
      nonzero_q     = '0;
      position_q    = '0;
    end
  endfunction

  function automatic logic signed [31:0] random_content(input int unsigned zero_pct);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < zero_pct) return '0;
    case ($urandom_range(9))
      0: return CONTENT_MIN;
      1: return CONTENT_MAX;
      2: return -32'sd1;
      3: return 32'sd1;
      4, 5: return $signed(32'($urandom_range(2047))) - 32'sd1024;
      default: return $signed($urandom);
    endcase
  endfunction

  function automatic logic [23:0] random_error();
    case ($urandom_range(9))
      0: return '0;
      1: return ERR_MAX;
      2, 3: return 24'($urandom_range(255));
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_OFF: begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      IDLE_SENDER: begin
        gap_pct   = 84;
        stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        gap_pct   = 0;
        stall_pct = 84;
      end
      default: begin
        gap_pct   = 28;
        stall_pct = 28;
      end
    endcase
  endtask

  // One bin request, with a random idle gap in front
  task automatic send_bin(input logic signed [31:0] content, input logic [23:0] err);
    bin_t b;
    b.bin_content = content;
    b.bin_error   = err;
    while ($urandom_range(99) < gap_pct) begin
      bin_if.valid <= 1'b0;
      @(posedge clk);
    end
    bin_if.valid <= 1'b1;
    bin_if.data  <= b;
    @(posedge clk);
    while (!bin_if.ready) @(posedge clk);
    accumulate_bin(b);
  endtask

  // Stop sending, let every pending group drain, then let the last bin finish
  task automatic wait_until_idle();
    bin_if.valid <= 1'b0;
    while (expected_groups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_group_size(input cfg_t value);
    wait_until_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    group_size_q = value;
  endtask

  // Edge values, default size, empty group, size zero and a mid-group shrink
  task automatic test_directed_edges();
    set_idling(IDLE_OFF);
    send_bin(CONTENT_MAX, ERR_MAX);
    send_bin(CONTENT_MIN, '0);
    send_bin('0, ERR_MAX);
    send_bin(-32'sd1, 24'd1);
    send_bin(32'sd1, ERR_MAX);
    send_bin('0, '0);
    for (int i = 0; i < 14; i++) begin
      send_bin((i % 2) ? CONTENT_MIN : 32'sh0001_0000, ERR_MAX - 24'(i));
    end
    write_group_size(7'd0);
    send_bin('0, ERR_MAX);
    send_bin(CONTENT_MIN, ERR_MAX);
    write_group_size(7'd3);
    send_bin(32'sh0002_8000, 24'h01_0000);
    send_bin(-32'sd65536, 24'h00_8000);
    // two bins already taken, so the group closes on the next one
    write_group_size(7'd1);
    send_bin(CONTENT_MAX, 24'h00_0001);
  endtask

  // Long receiver hold-off fills the block; after a full drain both sides idle at random
  task automatic test_backpressure();
    write_group_size(7'd2);
    set_idling(IDLE_OFF);
    hold_req = 400;
    repeat (24) send_bin(random_content(20), random_error());
    wait_until_idle();
    set_idling(IDLE_BOTH);
    repeat (10) send_bin(random_content(20), random_error());
  endtask

  task automatic test_random_phases();
    cfg_t        plan [10];
    cfg_t        size;
    int unsigned span;
    int unsigned count;
    int unsigned zero_pct;
    plan = '{7'd127, 7'd64, 7'd1, 7'd2, 7'd5, 7'd10, 7'd65, 7'd3, 7'd40, 7'd0};
    for (int p = 0; p < 16; p++) begin
      if (p < 10) size = plan[p];
      else if (p == 15) size = 7'($urandom_range(127));
      else size = 7'($urandom_range(8, 1));
      write_group_size(size);
      set_idling(idle_mode_e'(p % 4));
      span = (size == 0) ? 1 : ((size > MAX_GROUP) ? MAX_GROUP : size);
      // large groups stop part-way so the sums ride over the next write
      count    = (span >= 32) ? span + span / 2 : 36;
      zero_pct = (p % 3 == 0) ? 70 : 20;
      repeat (count) send_bin(random_content(zero_pct), random_error());
    end
  endtask

  task automatic finish_run();
    wait_until_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  endtask

  // Receiver ready: random stalls, plus a counted hold-off on request
  initial begin : rx_ready
    int unsigned hold_left;
    hold_left    = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else begin
        res_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Compare each accepted result with the oldest pending group
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (expected_groups.size() == 0) begin
        errors++;
        $display("%t: unexpected result: expected none, actual mean %0d error %0d used %0d",
                 $time, $signed(res_if.data.group_mean), res_if.data.group_error,
                 res_if.data.bins_used);
      end else begin
        want = expected_groups.pop_front();
        if (res_if.data.group_mean !== want.group_mean) begin
          errors++;
          $display("%t: group_mean mismatch: expected %0d, actual %0d", $time,
                   $signed(want.group_mean), $signed(res_if.data.group_mean));
        end
        if (res_if.data.group_error !== want.group_error) begin
          errors++;
          $display("%t: group_error mismatch: expected %0d, actual %0d", $time,
                   want.group_error, res_if.data.group_error);
        end
        if (res_if.data.bins_used !== want.bins_used) begin
          errors++;
          $display("%t: bins_used mismatch: expected %0d, actual %0d", $time,
                   want.bins_used, res_if.data.bins_used);
        end
      end
    end
  end

  // Watchdog: too long without any accepted request
  always @(posedge clk) begin : watchdog
    int unsigned quiet_cycles;
    if ((bin_if.valid && bin_if.ready) || (cfg_if.valid && cfg_if.ready) ||
        (res_if.valid && res_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%t: watchdog: no request accepted for %0d cycles", $time, STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    bin_if.valid = 1'b0;
    bin_if.data  = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;

    // state after reset
    group_size_q  = GROUP_SIZE_RST;
    content_sum_q = '0;
    err_sq_sum_q  = '0;
    nonzero_q     = '0;
    position_q    = '0;
    set_idling(IDLE_OFF);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_edges();
    test_backpressure();
    test_random_phases();
    finish_run();
  end

endmodule
